FILE: rtl/ltdvd_pkg.sv
package ltdvd_pkg;

  // Lead-byte masks of the compressed-integer code.
  localparam logic [7:0] MultiByteBit = 8'h80;
  localparam logic [7:0] FourByteBit  = 8'h40;
  localparam logic [7:0] TwoByteMask  = 8'h3f;
  localparam logic [7:0] FourByteMask = 8'h1f;
  localparam logic [7:0] EscapeByte   = 8'hff;

  // Bytes still owed after a lead byte.
  localparam logic [2:0] TwoByteTail    = 3'd1;
  localparam logic [2:0] FourByteTail   = 3'd3;
  localparam logic [2:0] EscapeByteTail = 3'd4;

  // Which value of the table is expected next.
  typedef enum logic [1:0] {
    PH_COUNT  = 2'd0,
    PH_SOURCE = 2'd1,
    PH_MACH   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // Result of shifting one byte into the value assembler.
  typedef struct packed {
    logic        done;
    logic [31:0] value;
    logic [2:0]  rem;
    logic [31:0] partial;
  } varint_t;

  // One decoded line-table entry.
  typedef struct packed {
    logic [31:0] source;
    logic [31:0] machine;
    logic        last;
  } entry_t;

endpackage

FILE: rtl/ltdvd_varint.sv
module ltdvd_varint (
  input  logic [2:0]             rem_i,
  input  logic [31:0]            partial_i,
  input  logic [7:0]             byte_i,
  output ltdvd_pkg::varint_t     res_o
);

  logic [31:0] shifted;

  assign shifted = {partial_i[23:0], byte_i};

  // Decode a lead byte or append a continuation byte.
  always_comb begin
    res_o.done    = 1'b0;
    res_o.value   = shifted;
    res_o.rem     = rem_i;
    res_o.partial = partial_i;
    if (rem_i == 3'd0) begin
      if ((byte_i & ltdvd_pkg::MultiByteBit) == 8'h00) begin
        res_o.done  = 1'b1;
        res_o.value = {24'd0, byte_i};
      end else if ((byte_i & ltdvd_pkg::FourByteBit) == 8'h00) begin
        res_o.partial = {24'd0, byte_i & ltdvd_pkg::TwoByteMask};
        res_o.rem     = ltdvd_pkg::TwoByteTail;
      end else if (byte_i != ltdvd_pkg::EscapeByte) begin
        res_o.partial = {24'd0, byte_i & ltdvd_pkg::FourByteMask};
        res_o.rem     = ltdvd_pkg::FourByteTail;
      end else begin
        res_o.partial = 32'd0;
        res_o.rem     = ltdvd_pkg::EscapeByteTail;
      end
    end else begin
      res_o.partial = shifted;
      res_o.rem     = rem_i - 3'd1;
      res_o.done    = (rem_i == 3'd1);
    end
  end

endmodule

FILE: rtl/ltdvd_outreg.sv
module ltdvd_outreg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ltdvd_pkg::entry_t   entry_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                stall_i,
  output ltdvd_pkg::entry_t   entry_o
);

  logic              vld_q, vld_d;
  ltdvd_pkg::entry_t entry_q, entry_d;

  // The register takes a new beat when it is empty or being drained.
  assign ready_o = !vld_q || !stall_i;

  always_comb begin
    vld_d   = vld_q;
    entry_d = entry_q;
    if (ready_o) begin
      vld_d = load_i;
      if (load_i) begin
        entry_d = entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = vld_q;
  assign entry_o = entry_q;

endmodule

FILE: rtl/line_table_delta_varint_decoder_unit.sv
// Line-table delta decoder: one byte of a compressed-integer line table per beat.
// Input channel: in_valid_i / in_stall_o carry data_byte_i and restart_i. A beat
// with restart_i set begins a new table; running offsets, count and any partly
// assembled value are cleared before that byte is used.
// Output channel: out_valid_o / out_stall_i carry one entry (source_offset_o,
// machine_offset_o, last_entry_o) for each completed pair of deltas. The first
// value of a table is the entry count; a count of zero or less gives no entry,
// and bytes after the final entry are dropped until the next restart.
// Throughput is one byte per cycle while the receiver does not stall. A byte
// is first captured in the input register, then decoded into the result
// register. The path between the two registers holds the 32-bit add of the
// machine offset; the source offset is summed into a held register first.
// Reset empties both registers and starts in the state that expects a count.
// When the receiver stalls, the entry holds in the result register; the byte
// behind it waits in the input register and in_stall_o rises only while both
// registers are full.
module line_table_delta_varint_decoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] source_offset_o,
  output logic signed [31:0] machine_offset_o,
  output logic               last_entry_o
);

  // Input register.
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q, byte_d;
  logic       restart_q, restart_d;

  // Decoder state.
  logic [2:0]        rem_q, rem_d;
  logic [31:0]       partial_q, partial_d;
  ltdvd_pkg::phase_e phase_q, phase_d;
  logic [30:0]       left_q, left_d;
  logic [31:0]       prev_src_q, prev_src_d;
  logic [31:0]       prev_mach_q, prev_mach_d;
  logic [31:0]       held_src_q, held_src_d;

  // State seen by the current byte, after a restart if one is asked for.
  logic [2:0]        rem_e;
  logic [31:0]       partial_e;
  ltdvd_pkg::phase_e phase_e;
  logic [30:0]       left_e;
  logic [31:0]       prev_src_e;
  logic [31:0]       prev_mach_e;

  ltdvd_pkg::varint_t vi;
  ltdvd_pkg::entry_t  entry_d, entry_q;
  logic               out_ready;
  logic               advance;
  logic               in_accept;
  logic               emit;
  logic [30:0]        left_dec;

  assign advance    = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register loads on an accepted beat and empties when decoded.
  always_comb begin
    in_vld_d  = in_vld_q;
    byte_d    = byte_q;
    restart_d = restart_q;
    if (in_accept) begin
      in_vld_d  = 1'b1;
      byte_d    = data_byte_i;
      restart_d = restart_i;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // A restart clears the state before the byte is used.
  always_comb begin
    if (restart_q) begin
      rem_e       = 3'd0;
      partial_e   = 32'd0;
      phase_e     = ltdvd_pkg::PH_COUNT;
      left_e      = 31'd0;
      prev_src_e  = 32'd0;
      prev_mach_e = 32'd0;
    end else begin
      rem_e       = rem_q;
      partial_e   = partial_q;
      phase_e     = phase_q;
      left_e      = left_q;
      prev_src_e  = prev_src_q;
      prev_mach_e = prev_mach_q;
    end
  end

  ltdvd_varint u_varint (
    .rem_i     (rem_e),
    .partial_i (partial_e),
    .byte_i    (byte_q),
    .res_o     (vi)
  );

  assign left_dec = left_e - 31'd1;

  // Walk the table: count, then source and machine deltas in turn.
  always_comb begin
    rem_d       = rem_q;
    partial_d   = partial_q;
    phase_d     = phase_q;
    left_d      = left_q;
    prev_src_d  = prev_src_q;
    prev_mach_d = prev_mach_q;
    held_src_d  = (advance && restart_q) ? 32'd0 : held_src_q;
    emit        = 1'b0;
    entry_d.source  = held_src_q;
    entry_d.machine = prev_mach_e + vi.value;
    entry_d.last    = (left_dec == 31'd0);
    if (advance) begin
      rem_d       = rem_e;
      partial_d   = partial_e;
      phase_d     = phase_e;
      left_d      = left_e;
      prev_src_d  = prev_src_e;
      prev_mach_d = prev_mach_e;
      if (phase_e != ltdvd_pkg::PH_DONE) begin
        rem_d     = vi.rem;
        partial_d = vi.partial;
        if (vi.done) begin
          unique case (phase_e)
            ltdvd_pkg::PH_COUNT: begin
              if (vi.value == 32'd0 || vi.value[31]) begin
                phase_d = ltdvd_pkg::PH_DONE;
              end else begin
                left_d  = vi.value[30:0];
                phase_d = ltdvd_pkg::PH_SOURCE;
              end
            end
            ltdvd_pkg::PH_SOURCE: begin
              held_src_d = prev_src_e + vi.value;
              phase_d    = ltdvd_pkg::PH_MACH;
            end
            ltdvd_pkg::PH_MACH: begin
              emit        = 1'b1;
              prev_mach_d = entry_d.machine;
              prev_src_d  = held_src_q;
              left_d      = left_dec;
              phase_d     = entry_d.last ? ltdvd_pkg::PH_DONE : ltdvd_pkg::PH_SOURCE;
            end
            default: begin
              phase_d = ltdvd_pkg::PH_DONE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      rem_q       <= 3'd0;
      partial_q   <= 32'd0;
      phase_q     <= ltdvd_pkg::PH_COUNT;
      left_q      <= 31'd0;
      prev_src_q  <= 32'd0;
      prev_mach_q <= 32'd0;
      held_src_q  <= 32'd0;
    end else begin
      in_vld_q    <= in_vld_d;
      rem_q       <= rem_d;
      partial_q   <= partial_d;
      phase_q     <= phase_d;
      left_q      <= left_d;
      prev_src_q  <= prev_src_d;
      prev_mach_q <= prev_mach_d;
      held_src_q  <= held_src_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    restart_q <= restart_d;
  end

  ltdvd_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .entry_i (entry_d),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .entry_o (entry_q)
  );

  assign source_offset_o  = $signed(entry_q.source);
  assign machine_offset_o = $signed(entry_q.machine);
  assign last_entry_o     = entry_q.last;

endmodule

FILE: rtl/ltdvd_checker.sv
module ltdvd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] source_offset_o,
  input logic [31:0] machine_offset_o,
  input logic        last_entry_o
);

  // A stalled entry stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(source_offset_o)
      && $stable(machine_offset_o) && $stable(last_entry_o))
    else $error("stalled entry changed");

  // Input backpressure only comes from a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A new entry appears only if the input was not stalled in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_stall_o))
    else $error("entry appeared while the input was stalled");

endmodule

bind line_table_delta_varint_decoder_unit ltdvd_checker u_ltdvd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .source_offset_o  (source_offset_o),
  .machine_offset_o (machine_offset_o),
  .last_entry_o     (last_entry_o)
);

FILE: dv/line_table_delta_varint_decoder_unit_test.sv
module line_table_delta_varint_decoder_unit_test;

  localparam int CycleLimit  = 200000;
  localparam int PhaseBeats  = 120;
  localparam int LongHold    = 200;
  localparam int SettleTicks = 8;

  // One directed beat, with the entry it completes typed in where that is obvious.
  typedef struct {
    logic [7:0]          data;
    logic                rs;
    logic                typed;
    ltdvd_pkg::entry_t   ent;
  } dir_row_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i      = '0;
  logic               restart_i        = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic signed [31:0] source_offset_o;
  logic signed [31:0] machine_offset_o;
  logic               last_entry_o;

  // Shadow of the decoder state.
  logic [2:0]        asm_rem      = '0;
  logic [31:0]       asm_value    = '0;
  ltdvd_pkg::phase_e tbl_phase    = ltdvd_pkg::PH_COUNT;
  logic [30:0]       entries_left = '0;
  logic [31:0]       prev_source  = '0;
  logic [31:0]       prev_machine = '0;
  logic [31:0]       held_source  = '0;

  ltdvd_pkg::entry_t entry_q[$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_req        = 0;
  int hold_ack        = 0;
  int hold_left       = 0;
  int cycle_cnt       = 0;
  int mismatch_cnt    = 0;
  int beats_sent      = 0;
  int live_beats      = 0;
  int tables_started  = 0;
  int entries_checked = 0;
  logic next_restart  = 1'b0;

  // Directed walk: a table before any restart, all four value forms, ignored
  // trailing bytes, zero and negative counts, restart inside a value.
  dir_row_t dir_rows [26] = '{
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h05, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b0, 1'b1, '{32'h0000_0005, 32'h0000_007f, 1'b0}},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hbf, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b1, '{32'h8000_0005, 32'h0000_407e, 1'b1}},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'he0, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, '0},
    '{8'hfe, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{32'h1e00_0001, 32'h0000_0000, 1'b1}}
  };

  line_table_delta_varint_decoder_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .source_offset_o  (source_offset_o),
    .machine_offset_o (machine_offset_o),
    .last_entry_o     (last_entry_o)
  );

  always #4 clk_i = ~clk_i;

  // Advances the shadow decoder by one byte and reports a completed entry.
  task automatic decode_line_byte(input logic [7:0] b, input logic rs,
                                  output logic got, output ltdvd_pkg::entry_t ent);
    logic        complete;
    logic [31:0] value;
    got      = 1'b0;
    ent      = '0;
    complete = 1'b0;
    value    = '0;
    if (rs) begin
      asm_rem      = '0;
      asm_value    = '0;
      tbl_phase    = ltdvd_pkg::PH_COUNT;
      entries_left = '0;
      prev_source  = '0;
      prev_machine = '0;
      held_source  = '0;
    end
    if (tbl_phase != ltdvd_pkg::PH_DONE) begin
      // Lead byte picks the length of the value; tail bytes shift in big-endian.
      if (asm_rem == 3'd0) begin
        if ((b & ltdvd_pkg::MultiByteBit) == 8'h00) begin
          value    = {24'h0, b};
          complete = 1'b1;
        end else if ((b & ltdvd_pkg::FourByteBit) == 8'h00) begin
          asm_value = {24'h0, b & ltdvd_pkg::TwoByteMask};
          asm_rem   = ltdvd_pkg::TwoByteTail;
        end else if (b != ltdvd_pkg::EscapeByte) begin
          asm_value = {24'h0, b & ltdvd_pkg::FourByteMask};
          asm_rem   = ltdvd_pkg::FourByteTail;
        end else begin
          asm_value = '0;
          asm_rem   = ltdvd_pkg::EscapeByteTail;
        end
      end else begin
        asm_value = {asm_value[23:0], b};
        asm_rem   = asm_rem - 3'd1;
        if (asm_rem == 3'd0) begin
          value    = asm_value;
          complete = 1'b1;
        end
      end
    end
    // A finished value is the count, a source delta or a machine delta.
    if (complete) begin
      case (tbl_phase)
        ltdvd_pkg::PH_COUNT: begin
          if (value == 32'h0 || value[31]) begin
            tbl_phase = ltdvd_pkg::PH_DONE;
          end else begin
            entries_left = value[30:0];
            tbl_phase    = ltdvd_pkg::PH_SOURCE;
          end
        end
        ltdvd_pkg::PH_SOURCE: begin
          held_source = prev_source + value;
          tbl_phase   = ltdvd_pkg::PH_MACH;
        end
        ltdvd_pkg::PH_MACH: begin
          prev_machine = prev_machine + value;
          prev_source  = held_source;
          entries_left = entries_left - 31'd1;
          got          = 1'b1;
          ent.source   = prev_source;
          ent.machine  = prev_machine;
          ent.last     = (entries_left == 31'd0);
          tbl_phase    = ent.last ? ltdvd_pkg::PH_DONE : ltdvd_pkg::PH_SOURCE;
        end
        default: begin
        end
      endcase
    end
  endtask

  // Offers one beat, waits for it to be taken, then records what it should cause.
  task automatic send_beat(input logic [7:0] b, input logic rs, input logic typed,
                           input ltdvd_pkg::entry_t typed_ent);
    logic              got;
    ltdvd_pkg::entry_t ent;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    restart_i   <= rs;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (rs || tbl_phase != ltdvd_pkg::PH_DONE) live_beats++;
    if (rs) tables_started++;
    decode_line_byte(b, rs, got, ent);
    if (typed) begin
      entry_q.push_back(typed_ent);
    end else if (got) begin
      entry_q.push_back(ent);
    end
  endtask

  // Sends a byte of a table; the first byte carries a restart if next_restart is set.
  task automatic put(input logic [7:0] b);
    send_beat(b, next_restart, 1'b0, '0);
    next_restart = 1'b0;
  endtask

  // One signed delta in a randomly chosen form with random content.
  task automatic send_delta();
    case ($urandom_range(3))
      0: put(8'($urandom_range(127)));
      1: begin
        put(8'h80 | 8'($urandom_range(63)));
        put(8'($urandom_range(255)));
      end
      2: begin
        put(8'($urandom_range(8'hfe, 8'hc0)));
        repeat (3) put(8'($urandom_range(255)));
      end
      default: begin
        put(ltdvd_pkg::EscapeByte);
        repeat (4) put(8'($urandom_range(255)));
      end
    endcase
  endtask

  // Entry count: mostly small and positive, sometimes zero, negative or huge.
  task automatic send_count(output int n);
    int r;
    r = $urandom_range(99);
    n = $urandom_range(6, 1);
    if (r < 60) begin
      put(8'(n));
    end else if (r < 70) begin
      put(8'h80);
      put(8'(n));
    end else if (r < 78) begin
      put($urandom_range(1) ? 8'he0 : 8'hc0);
      put(8'h00);
      put(8'h00);
      put(8'(n));
    end else if (r < 84) begin
      put(ltdvd_pkg::EscapeByte);
      repeat (3) put(8'h00);
      put(8'(n));
    end else if (r < 92) begin
      n = 0;
      case ($urandom_range(2))
        0: put(8'h00);
        1: begin
          put(ltdvd_pkg::EscapeByte);
          put(8'h80 | 8'($urandom_range(127)));
          repeat (3) put(8'($urandom_range(255)));
        end
        default: begin
          put(8'h80);
          put(8'h00);
        end
      endcase
    end else begin
      n = 1000;
      if ($urandom_range(1)) begin
        put(ltdvd_pkg::EscapeByte);
        put(8'h7f);
        repeat (3) put(8'hff);
      end else begin
        put(8'hbf);
        put(8'hff);
      end
    end
  endtask

  // A well-formed table most of the time; also noise, cut-off and trailing bytes.
  task automatic random_step();
    int kind;
    int n;
    int pairs;
    int cut;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(4, 1)) begin
        send_beat(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, '0);
      end
    end else begin
      next_restart = (kind >= 17);
      send_count(n);
      pairs = (n > 6) ? $urandom_range(4, 1) : n;
      cut = ($urandom_range(9) == 0) ? $urandom_range(pairs) : -1;
      for (int k = 0; k < pairs; k++) begin
        if (k == cut) begin
          if ($urandom_range(1)) send_delta();
          put(ltdvd_pkg::EscapeByte);
          put(8'($urandom_range(255)));
          break;
        end
        send_delta();
        send_delta();
      end
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(3, 1)) put(8'($urandom_range(255)));
      end
    end
  endtask

  // Sender goes quiet until every expected entry has been taken.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic flag_entry(input string why, input ltdvd_pkg::entry_t want,
                            input ltdvd_pkg::entry_t seen);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%s: expected src %h mach %h last %b, got src %h mach %h last %b",
               why, want.source, want.machine, want.last,
               seen.source, seen.machine, seen.last);
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LongHold;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Each entry beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    ltdvd_pkg::entry_t seen;
    ltdvd_pkg::entry_t want;
    seen = {source_offset_o, machine_offset_o, last_entry_o};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (entry_q.size() == 0) begin
        flag_entry("entry with none expected", '0, seen);
      end else begin
        want = entry_q.pop_front();
        entries_checked++;
        if (seen.source !== want.source || seen.machine !== want.machine ||
            seen.last !== want.last) begin
          flag_entry("entry mismatch", want, seen);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int target;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].data, dir_rows[i].rs, dir_rows[i].typed, dir_rows[i].ent);
    end
    settle();

    // Random tables under four mixes of sender gaps and receiver stalls.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req++;
        end
        1: begin
          send_idle_pct  = 80;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 80;
        end
        default: begin
          send_idle_pct  = 15;
          recv_stall_pct = 15;
        end
      endcase
      target = live_beats + PhaseBeats;
      while (live_beats < target) random_step();
      settle();
    end

    $display("Run covered %0d beats (%0d decoded), %0d tables started, %0d entries checked,",
             beats_sent, live_beats, tables_started, entries_checked);
    $display("with gap and stall mixes, a long output hold-off and a full drain between them.");
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ltdvd_pkg.sv
rtl/ltdvd_varint.sv
rtl/ltdvd_outreg.sv
rtl/line_table_delta_varint_decoder_unit.sv
rtl/ltdvd_checker.sv
dv/line_table_delta_varint_decoder_unit_test.sv
